FILE: hw/rtl/ltc_pkg.sv
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared types, widths and helpers for the LRU tag cache.
// ----------------------------------------------------------------------------
package ltc_pkg;

   localparam int NUM_ENTRIES_DEF = 16;
   localparam int KEY_W           = 32;
   localparam int HANDLE_W        = 32;
   localparam int STAMP_W         = 32;

   typedef enum logic [2:0] {
      OP_ZERO,
      OP_LOOKUP_HIT,
      OP_INSERT_HIT,
      OP_FILL,
      OP_EVICT
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [KEY_W-1:0]      key;
      logic [HANDLE_W-1:0]   handle;
   } cmd_type;

   typedef struct packed {
      logic                  done;
      logic                  key_wr;
      logic [KEY_W-1:0]      key;
   } back_stat_type;

   function automatic int idx_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

FILE: hw/rtl/lru_tag_cache.sv
// ----------------------------------------------------------------------------
// lru_tag_cache
// Fully associative key/handle cache with timestamp LRU replacement.
// ----------------------------------------------------------------------------
//   channel    | ports                                       | handshake
//   -----------+---------------------------------------------+-----------------
//   request    | req_type, req_key, req_handle               | start && !busy
//   response   | rsp_hit, rsp_data_out, rsp_evicted,         | rsp_strobe, one
//              | rsp_evicted_key                             | cycle, no stall
//
// One request at a time. Misses, null inserts, insert hits and fills are
// answered from the idle state, a lookup hit also waits for the registered
// handle read, and an evicting insert runs the victim scan, which reads one
// stamp per cycle from the stamp memory.
// Reset is synchronous; it empties the store through the fill count, with no
// clearing pass. busy is high during reset. Responses cannot be stalled.
// ----------------------------------------------------------------------------
module lru_tag_cache #(
   parameter int NUM_ENTRIES = ltc_pkg::NUM_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [ltc_pkg::KEY_W-1:0]     req_key,
   input  logic [ltc_pkg::HANDLE_W-1:0]  req_handle,
   output logic                          rsp_strobe,
   output logic                          rsp_hit,
   output logic [ltc_pkg::HANDLE_W-1:0]  rsp_data_out,
   output logic                          rsp_evicted,
   output logic [ltc_pkg::KEY_W-1:0]     rsp_evicted_key
);

   localparam int IDX_W = ltc_pkg::idx_width(NUM_ENTRIES);
   localparam int Q_W   = $bits(ltc_pkg::cmd_type) + IDX_W;

   ltc_pkg::back_stat_type stat;
   logic [IDX_W-1:0]       stat_idx;
   logic                   push;
   logic [Q_W-1:0]         push_data;
   logic                   pop;
   logic                   q_vld;
   logic [Q_W-1:0]         q_data;

   ltc_front #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_type   (req_type),
      .req_key    (req_key),
      .req_handle (req_handle),
      .stat       (stat),
      .stat_idx   (stat_idx),
      .push       (push),
      .push_data  (push_data)
   );

   ltc_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .q_vld     (q_vld),
      .q_data    (q_data)
   );

   ltc_back #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_vld           (q_vld),
      .q_data          (q_data),
      .pop             (pop),
      .stat            (stat),
      .stat_idx        (stat_idx),
      .rsp_strobe      (rsp_strobe),
      .rsp_hit         (rsp_hit),
      .rsp_data_out    (rsp_data_out),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key)
   );

endmodule

FILE: hw/rtl/ltc_ram.sv
// ----------------------------------------------------------------------------
// ltc_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ltc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [ltc_pkg::idx_width(DEPTH)-1:0]    wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [ltc_pkg::idx_width(DEPTH)-1:0]    rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/ltc_queue.sv
// ----------------------------------------------------------------------------
// ltc_queue
// Two-entry command queue between the classifier and the execution unit.
// ----------------------------------------------------------------------------
module ltc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             q_vld,
   output logic [WIDTH-1:0] q_data
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign do_push = push && (cnt_ff != 2'd2);
   assign do_pop  = pop && (cnt_ff != 2'd0);

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign q_vld  = (cnt_ff != 2'd0);
   assign q_data = data_ff[rd_ptr_ff];

endmodule

FILE: hw/rtl/ltc_front.sv
// ----------------------------------------------------------------------------
// ltc_front
// Request intake: key match cells, fill count and request classification.
// ----------------------------------------------------------------------------
module ltc_front #(
   parameter int NUM_ENTRIES = ltc_pkg::NUM_ENTRIES_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   output logic                                          busy,
   input  logic                                          req_type,
   input  logic [ltc_pkg::KEY_W-1:0]                     req_key,
   input  logic [ltc_pkg::HANDLE_W-1:0]                  req_handle,
   input  ltc_pkg::back_stat_type                        stat,
   input  logic [ltc_pkg::idx_width(NUM_ENTRIES)-1:0]    stat_idx,
   output logic                                          push,
   output logic [$bits(ltc_pkg::cmd_type)+ltc_pkg::idx_width(NUM_ENTRIES)-1:0] push_data
);

   localparam int   IDX_W      = ltc_pkg::idx_width(NUM_ENTRIES);
   localparam int   CNT_W      = $clog2(NUM_ENTRIES + 1);
   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic [ltc_pkg::HANDLE_W-1:0] HANDLE_NULL = '0;

   logic [ltc_pkg::KEY_W-1:0]    key_ff [NUM_ENTRIES];
   logic [CNT_W-1:0]             fill_ff, fill_in;
   logic                         busy_ff, busy_in;
   logic                         vld_ff;
   logic                         type_ff;
   logic [ltc_pkg::KEY_W-1:0]    req_key_ff;
   logic [ltc_pkg::HANDLE_W-1:0] req_handle_ff;
   logic                         accept;
   logic [NUM_ENTRIES-1:0]       match;
   logic                         hit_any;
   logic [IDX_W-1:0]             hit_idx;
   logic                         full;
   ltc_pkg::cmd_type             cmd;
   logic [IDX_W-1:0]             cmd_idx;
   logic                         fill_wr;

   assign accept = start && !busy_ff;

   always_comb begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         match[i] = (CNT_W'(i) < fill_ff) && (key_ff[i] == req_key_ff);
      end
   end

   // keys are unique among occupied slots, so an OR encode is enough
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (match[i]) begin
            hit_idx = hit_idx | IDX_W'(i);
         end
      end
   end

   assign hit_any = |match;
   assign full    = (fill_ff == CNT_W'(NUM_ENTRIES));

   always_comb begin
      cmd.key    = req_key_ff;
      cmd.handle = req_handle_ff;
      cmd.op     = ltc_pkg::OP_ZERO;
      cmd_idx    = hit_idx;
      if (type_ff == REQ_LOOKUP) begin
         cmd.op = hit_any ? ltc_pkg::OP_LOOKUP_HIT : ltc_pkg::OP_ZERO;
      end else if (req_handle_ff == HANDLE_NULL) begin
         cmd.op = ltc_pkg::OP_ZERO;
      end else if (hit_any) begin
         cmd.op = ltc_pkg::OP_INSERT_HIT;
      end else if (!full) begin
         cmd.op  = ltc_pkg::OP_FILL;
         cmd_idx = fill_ff[IDX_W-1:0];
      end else begin
         cmd.op  = ltc_pkg::OP_EVICT;
         cmd_idx = '0;
      end
   end

   assign fill_wr = vld_ff && (cmd.op == ltc_pkg::OP_FILL);

   always_comb begin
      fill_in = fill_wr ? fill_ff + CNT_W'(1) : fill_ff;
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (stat.done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         vld_ff  <= 1'b0;
         fill_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         vld_ff  <= accept;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff       <= req_type;
         req_key_ff    <= req_key;
         req_handle_ff <= req_handle;
      end
      if (fill_wr) begin
         key_ff[fill_ff[IDX_W-1:0]] <= req_key_ff;
      end else if (stat.key_wr) begin
         key_ff[stat_idx] <= stat.key;
      end
   end

   assign busy      = busy_ff || reset;
   assign push      = vld_ff;
   assign push_data = {cmd, cmd_idx};

endmodule

FILE: hw/rtl/ltc_back.sv
// ----------------------------------------------------------------------------
// ltc_back
// Execution unit: handle and stamp memories, access clock, LRU victim scan
// and response register.
// ----------------------------------------------------------------------------
module ltc_back #(
   parameter int NUM_ENTRIES = ltc_pkg::NUM_ENTRIES_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          q_vld,
   input  logic [$bits(ltc_pkg::cmd_type)+ltc_pkg::idx_width(NUM_ENTRIES)-1:0] q_data,
   output logic                                          pop,
   output ltc_pkg::back_stat_type                        stat,
   output logic [ltc_pkg::idx_width(NUM_ENTRIES)-1:0]    stat_idx,
   output logic                                          rsp_strobe,
   output logic                                          rsp_hit,
   output logic [ltc_pkg::HANDLE_W-1:0]                  rsp_data_out,
   output logic                                          rsp_evicted,
   output logic [ltc_pkg::KEY_W-1:0]                     rsp_evicted_key
);

   localparam int IDX_W = ltc_pkg::idx_width(NUM_ENTRIES);
   localparam int KH_W  = ltc_pkg::KEY_W + ltc_pkg::HANDLE_W;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_LOOKUP  = 5'b00010,
      ST_SCAN    = 5'b00100,
      ST_DRAIN   = 5'b01000,
      ST_REPLACE = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   ltc_pkg::cmd_type              q_cmd;
   logic [IDX_W-1:0]              q_idx;
   ltc_pkg::cmd_type              cmd_ff, cmd_in;
   logic [ltc_pkg::STAMP_W-1:0]   clock_ff, clock_in, next_stamp;
   logic [IDX_W-1:0]              scan_ff, scan_in;
   logic                          scan_vld_ff;
   logic [IDX_W-1:0]              scan_idx_ff;
   logic [ltc_pkg::STAMP_W-1:0]   best_stamp_ff;
   logic [IDX_W-1:0]              best_idx_ff;
   logic [ltc_pkg::KEY_W-1:0]     best_key_ff;

   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic                          rsp_hit_ff, rsp_hit_in;
   logic [ltc_pkg::HANDLE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                          rsp_ev_ff, rsp_ev_in;
   logic [ltc_pkg::KEY_W-1:0]     rsp_ev_key_ff, rsp_ev_key_in;

   logic                          kh_wr_en;
   logic [IDX_W-1:0]              kh_wr_addr;
   logic [KH_W-1:0]               kh_wr_data;
   logic                          kh_rd_en;
   logic [IDX_W-1:0]              kh_rd_addr;
   logic [KH_W-1:0]               kh_rd_data;
   logic                          st_wr_en;
   logic [IDX_W-1:0]              st_wr_addr;
   logic                          st_rd_en;
   logic [ltc_pkg::STAMP_W-1:0]   st_rd_data;
   logic                          key_wr;

   assign {q_cmd, q_idx} = q_data;
   assign next_stamp     = clock_ff + ltc_pkg::STAMP_W'(1);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      clock_in      = clock_ff;
      scan_in       = scan_ff;
      pop           = 1'b0;
      key_wr        = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_hit_in    = 1'b0;
      rsp_data_in   = '0;
      rsp_ev_in     = 1'b0;
      rsp_ev_key_in = '0;
      kh_wr_en      = 1'b0;
      kh_wr_addr    = q_idx;
      kh_wr_data    = {q_cmd.key, q_cmd.handle};
      kh_rd_en      = 1'b0;
      kh_rd_addr    = scan_ff;
      st_wr_en      = 1'b0;
      st_wr_addr    = q_idx;
      st_rd_en      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            kh_rd_addr = q_idx;
            if (q_vld) begin
               pop = 1'b1;
               case (q_cmd.op)
                  ltc_pkg::OP_LOOKUP_HIT: begin
                     st_wr_en = 1'b1;
                     clock_in = next_stamp;
                     kh_rd_en = 1'b1;
                     state_in = ST_LOOKUP;
                  end
                  ltc_pkg::OP_INSERT_HIT: begin
                     st_wr_en      = 1'b1;
                     clock_in      = next_stamp;
                     rsp_strobe_in = 1'b1;
                     rsp_hit_in    = 1'b1;
                  end
                  ltc_pkg::OP_FILL: begin
                     st_wr_en      = 1'b1;
                     kh_wr_en      = 1'b1;
                     clock_in      = next_stamp;
                     rsp_strobe_in = 1'b1;
                  end
                  ltc_pkg::OP_EVICT: begin
                     cmd_in   = q_cmd;
                     scan_in  = '0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            rsp_strobe_in = 1'b1;
            rsp_hit_in    = 1'b1;
            rsp_data_in   = kh_rd_data[ltc_pkg::HANDLE_W-1:0];
            state_in      = ST_IDLE;
         end
         ST_SCAN: begin
            kh_rd_en = 1'b1;
            st_rd_en = 1'b1;
            scan_in  = scan_ff + IDX_W'(1);
            if (scan_ff == IDX_W'(NUM_ENTRIES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_REPLACE;
         end
         ST_REPLACE: begin
            kh_wr_en      = 1'b1;
            kh_wr_addr    = best_idx_ff;
            kh_wr_data    = {cmd_ff.key, cmd_ff.handle};
            st_wr_en      = 1'b1;
            st_wr_addr    = best_idx_ff;
            clock_in      = next_stamp;
            key_wr        = 1'b1;
            rsp_strobe_in = 1'b1;
            rsp_ev_in     = 1'b1;
            rsp_ev_key_in = best_key_ff;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         clock_ff      <= '0;
         scan_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clock_ff      <= clock_in;
         scan_vld_ff   <= (state_ff == ST_SCAN);
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // keep the first slot, then take a strictly smaller stamp
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      scan_ff       <= scan_in;
      scan_idx_ff   <= scan_ff;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_ev_key_ff <= rsp_ev_key_in;
      if (scan_vld_ff && ((scan_idx_ff == '0) || (st_rd_data < best_stamp_ff))) begin
         best_stamp_ff <= st_rd_data;
         best_idx_ff   <= scan_idx_ff;
         best_key_ff   <= kh_rd_data[KH_W-1:ltc_pkg::HANDLE_W];
      end
   end

   ltc_ram #(
      .WIDTH (KH_W),
      .DEPTH (NUM_ENTRIES)
   ) u_kh_ram (
      .clock   (clock),
      .wr_en   (kh_wr_en),
      .wr_addr (kh_wr_addr),
      .wr_data (kh_wr_data),
      .rd_en   (kh_rd_en),
      .rd_addr (kh_rd_addr),
      .rd_data (kh_rd_data)
   );

   ltc_ram #(
      .WIDTH (ltc_pkg::STAMP_W),
      .DEPTH (NUM_ENTRIES)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (next_stamp),
      .rd_en   (st_rd_en),
      .rd_addr (scan_ff),
      .rd_data (st_rd_data)
   );

   assign stat.done   = rsp_strobe_in;
   assign stat.key_wr = key_wr;
   assign stat.key    = cmd_ff.key;
   assign stat_idx    = best_idx_ff;

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_evicted     = rsp_ev_ff;
   assign rsp_evicted_key = rsp_ev_key_ff;

endmodule

FILE: hw/rtl/ltc_checker.sv
// ----------------------------------------------------------------------------
// ltc_checker
// Port-level checks for the LRU tag cache, bound to the top level.
// ----------------------------------------------------------------------------
module ltc_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          rsp_strobe,
   input  logic                          rsp_hit,
   input  logic [ltc_pkg::HANDLE_W-1:0]  rsp_data_out,
   input  logic                          rsp_evicted,
   input  logic [ltc_pkg::KEY_W-1:0]     rsp_evicted_key
);

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_strobe_gap : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back responses");

   a_hit_evict : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_hit && rsp_evicted))
      else $error("response both hit and evicted");

   a_evict_key : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_evicted) |-> (rsp_evicted_key == '0))
      else $error("evicted key set without eviction");

   a_miss_data : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_hit) |-> (rsp_data_out == '0))
      else $error("handle returned on a miss");

endmodule

bind lru_tag_cache ltc_checker u_checker (.*);
